// ===== hw/rtl/swmq_pkg.sv =====
// Shared constants for the sliding-window mean and quantile block.
// No dependencies; used by the interfaces, the top level and the bench.
`default_nettype none

package swmq_pkg;

  // Default sizing of the block
  localparam int MAX_WIDTH_DEF   = 32;
  localparam int NUM_PROBS_DEF   = 4;
  localparam int SAMPLE_BITS_DEF = 16;

  // Configuration port shape
  localparam int CFG_IW = 3;
  localparam int CFG_DW = 17;

  // Register indexes
  localparam logic [CFG_IW-1:0] REG_WIDTH  = 3'd0;
  localparam logic [CFG_IW-1:0] REG_ALIGN  = 3'd1;
  localparam logic [CFG_IW-1:0] REG_FRAC   = 3'd2;
  localparam logic [CFG_IW-1:0] REG_MODE   = 3'd3;
  localparam logic [CFG_IW-1:0] REG_PROB_A = 3'd4;
  localparam logic [CFG_IW-1:0] REG_PROB_B = 3'd5;
  localparam logic [CFG_IW-1:0] REG_PROB_C = 3'd6;
  localparam logic [CFG_IW-1:0] REG_PROB_D = 3'd7;

  // Alignment codes
  localparam logic [1:0] ALIGN_RIGHT  = 2'd0;
  localparam logic [1:0] ALIGN_LEFT   = 2'd1;
  localparam logic [1:0] ALIGN_CENTRE = 2'd2;

  // Statistic mode codes
  localparam logic [1:0] MODE_MEAN  = 2'd0;
  localparam logic [1:0] MODE_QUANT = 2'd1;
  localparam logic [1:0] MODE_BOTH  = 2'd2;

  // Q1.16 one
  localparam logic [16:0] ONE_Q16 = 17'h10000;

  // Register reset values
  localparam logic [5:0]  WIDTH_RST  = 6'd24;
  localparam logic [1:0]  ALIGN_RST  = ALIGN_RIGHT;
  localparam logic [16:0] FRAC_RST   = 17'd49152;
  localparam logic [1:0]  MODE_RST   = MODE_MEAN;
  localparam logic [16:0] PROB_A_RST = 17'd32768;
  localparam logic [16:0] PROB_B_RST = 17'd16384;
  localparam logic [16:0] PROB_C_RST = 17'd49152;
  localparam logic [16:0] PROB_D_RST = 17'd62259;

endpackage

`default_nettype wire

// ===== hw/rtl/swmq_if.sv =====
// Valid/ready channel interfaces for sample items and result items.
// Depends on swmq_pkg for the default sample width.
`default_nettype none

interface swmq_in_if #(
  parameter int SAMPLE_BITS = swmq_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          missing;
  logic                          stream_end;

  modport source(output valid, sample, missing, stream_end, input ready);
  modport sink(input valid, sample, missing, stream_end, output ready);
endinterface

interface swmq_out_if #(
  parameter int SAMPLE_BITS = swmq_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] mean_value;
  logic                          mean_ok;
  logic signed [SAMPLE_BITS-1:0] quant_a;
  logic signed [SAMPLE_BITS-1:0] quant_b;
  logic signed [SAMPLE_BITS-1:0] quant_c;
  logic signed [SAMPLE_BITS-1:0] quant_d;
  logic                          quant_ok;
  logic [5:0]                    present_count;
  logic                          final_result;

  modport source(output valid, mean_value, mean_ok, quant_a, quant_b, quant_c, quant_d,
                 quant_ok, present_count, final_result, input ready);
  modport sink(input valid, mean_value, mean_ok, quant_a, quant_b, quant_c, quant_d,
               quant_ok, present_count, final_result, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/sliding_window_mean_quantile.sv =====
// Sliding-window mean and quantiles: top level with the sequencer and datapath.
// Depends on swmq_pkg, swmq_if, swmq_ram and swmq_div.
//
// Usage: sample items enter on "samples" (valid/ready), result items leave on
// "results" (valid/ready). Registers are written through cfg_wen/cfg_addr/
// cfg_wdata; the user must write them only while the block is idle, which
// the block itself does not enforce. Each sample item is written into a
// ring of MAX_WIDTH entries and then yields zero or one result item, or,
// when it carries stream_end, one result item per pending position, the last
// one flagged final_result. The block holds one item at a time: samples.ready
// is high only while nothing is in work. Per result the sequencer walks the
// window once for count and sum, runs the serial divider for the mean, ranks
// each present entry against every window entry through the one ring read
// port and then computes each quantile; with a window width of 32 and both
// statistics the ranking loop dominates. A result waits in its output
// register for as long as results.ready is low; nothing else advances
// meanwhile. Reset (rst, synchronous) clears the window, position and
// registers to defaults.
`default_nettype none

module sliding_window_mean_quantile #(
  parameter int MAX_WIDTH   = swmq_pkg::MAX_WIDTH_DEF,
  parameter int NUM_PROBS   = swmq_pkg::NUM_PROBS_DEF,
  parameter int SAMPLE_BITS = swmq_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_wen,
  input  wire logic [swmq_pkg::CFG_IW-1:0] cfg_addr,
  input  wire logic [swmq_pkg::CFG_DW-1:0] cfg_wdata,
  swmq_in_if.sink                          samples,
  swmq_out_if.source                       results
);
  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int SW = SAMPLE_BITS + CW;
  localparam int SB = SAMPLE_BITS;

  // Sequencer states
  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_EMIT  = 5'd1;
  localparam logic [4:0] S_SRD   = 5'd2;
  localparam logic [4:0] S_SAC   = 5'd3;
  localparam logic [4:0] S_QUAL  = 5'd4;
  localparam logic [4:0] S_DIVGO = 5'd5;
  localparam logic [4:0] S_DIVW  = 5'd6;
  localparam logic [4:0] S_RICHK = 5'd7;
  localparam logic [4:0] S_RIRD  = 5'd8;
  localparam logic [4:0] S_RILAT = 5'd9;
  localparam logic [4:0] S_RJRD  = 5'd10;
  localparam logic [4:0] S_RJAC  = 5'd11;
  localparam logic [4:0] S_RWR   = 5'd12;
  localparam logic [4:0] S_QMUL  = 5'd13;
  localparam logic [4:0] S_QRD0  = 5'd14;
  localparam logic [4:0] S_QRD1  = 5'd15;
  localparam logic [4:0] S_QPRD  = 5'd16;
  localparam logic [4:0] S_QADD  = 5'd17;
  localparam logic [4:0] S_OUT   = 5'd18;

  localparam logic [1:0] ALIGN_LEFT_C   = swmq_pkg::ALIGN_LEFT;
  localparam logic [1:0] ALIGN_CENTRE_C = swmq_pkg::ALIGN_CENTRE;

  // Configuration registers
  logic [5:0]  window_width;
  logic [1:0]  alignment;
  logic [16:0] min_fraction;
  logic [1:0]  stat_mode;
  logic [16:0] prob_a, prob_b, prob_c, prob_d;

  // Stream state
  logic [MAX_WIDTH-1:0] present;
  logic [31:0]          stream_position;
  logic [AW-1:0]        ring_head;

  // Sequencer and datapath registers
  logic [4:0]          st;
  logic                end_mode;
  logic [AW-1:0]       k;
  logic [CW-1:0]       w_r;
  logic [AW-1:0]       lead_r;
  logic [AW-1:0]       hi;
  logic [AW-1:0]       d;
  logic [AW-1:0]       i;
  logic [CW-1:0]       c;
  logic signed [SW-1:0] sum;
  logic [CW-1:0]       rank;
  logic signed [SB-1:0] vi;
  logic                ok;
  logic [1:0]          a;
  logic [16+CW:0]      idx;
  logic signed [SB-1:0] q0;
  logic [SB-1:0]       frac_prod;
  logic                interp;
  logic signed [SB-1:0] mean_r;
  logic                mean_ok_r;
  logic                quant_ok_r;
  logic signed [SB-1:0] q_res [4];

  // Memory and divider wires
  logic [AW-1:0] ring_raddr, sc_raddr;
  logic [SB-1:0] ring_rdata, sc_rdata;
  logic          accept;
  logic          div_done;
  logic [SW-1:0] div_q;
  logic [SW-1:0] sum_mag;

  // Combinational helpers
  logic [CW-1:0]  w_eff;
  logic [AW-1:0]  wm1, lead_now;
  logic           do_mean, do_q;
  logic [16+CW:0] need;
  logic [16+CW:0] have;
  logic [16:0]    psel, psat;
  logic [CW:0]    lo;
  logic           vj_less;
  logic signed [SB:0] diff;
  logic [SB+15:0] frac_full;

  // Ring slot d positions before the newest entry
  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] h, input logic [AW-1:0] dd);
    logic [AW:0] s;
    s = {1'b0, h} + (AW+1)'(MAX_WIDTH - 1) - {1'b0, dd};
    if (s >= (AW+1)'(MAX_WIDTH)) begin
      s = s - (AW+1)'(MAX_WIDTH);
    end
    return s[AW-1:0];
  endfunction

  assign accept = samples.valid && samples.ready;
  assign samples.ready = (st == S_IDLE);

  // Effective width and lead from the current registers
  always_comb begin
    if (window_width == 6'd0) begin
      w_eff = CW'(1);
    end else if ({1'b0, window_width} > 7'(MAX_WIDTH)) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = CW'(window_width);
    end
    wm1 = AW'(w_eff - 1'b1);
    case (alignment)
      ALIGN_LEFT_C:   lead_now = wm1;
      ALIGN_CENTRE_C: lead_now = wm1 - (wm1 >> 1);
      default:        lead_now = '0;
    endcase
  end

  assign do_mean = (stat_mode != swmq_pkg::MODE_QUANT);
  assign do_q    = (stat_mode != swmq_pkg::MODE_MEAN);
  assign need    = (17+CW)'(min_fraction * w_r);
  assign have    = (17+CW)'({c, 16'b0});

  // Quantile probability select and saturation
  always_comb begin
    case (a)
      2'd0:    psel = prob_a;
      2'd1:    psel = prob_b;
      2'd2:    psel = prob_c;
      default: psel = prob_d;
    endcase
    psat = (psel > swmq_pkg::ONE_Q16) ? swmq_pkg::ONE_Q16 : psel;
  end
  assign lo   = (CW+1)'(idx >> 16);
  assign diff = {sc_rdata[SB-1], sc_rdata} - {q0[SB-1], q0};

  // Full fraction times gap product, top bits give the floored step
  assign frac_full = idx[15:0] * diff[SB-1:0];

  // Rank order: smaller value, ties broken by ring distance
  assign vj_less = ($signed(ring_rdata) < vi) || (($signed(ring_rdata) == vi) && (d < i));

  // Read address selection
  assign ring_raddr = slot_of(ring_head, (st == S_RIRD) ? i : d);
  assign sc_raddr   = (st == S_QRD0) ? lo[AW-1:0] : AW'(lo + 1'b1);

  assign sum_mag = sum[SW-1] ? SW'(-sum) : SW'(sum);

  swmq_ram #(.WIDTH(SB), .DEPTH(MAX_WIDTH)) u_ring (
    .clk  (clk),
    .we   (accept),
    .waddr(ring_head),
    .wdata(samples.sample),
    .raddr(ring_raddr),
    .rdata(ring_rdata)
  );

  swmq_ram #(.WIDTH(SB), .DEPTH(MAX_WIDTH)) u_scratch (
    .clk  (clk),
    .we   (st == S_RWR),
    .waddr(rank[AW-1:0]),
    .wdata(vi),
    .raddr(sc_raddr),
    .rdata(sc_rdata)
  );

  swmq_div #(.NW(SW), .DW(CW)) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (st == S_DIVGO),
    .dividend(sum_mag),
    .divisor (c),
    .done    (div_done),
    .quotient(div_q)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      window_width <= swmq_pkg::WIDTH_RST;
      alignment    <= swmq_pkg::ALIGN_RST;
      min_fraction <= swmq_pkg::FRAC_RST;
      stat_mode    <= swmq_pkg::MODE_RST;
      prob_a       <= swmq_pkg::PROB_A_RST;
      prob_b       <= swmq_pkg::PROB_B_RST;
      prob_c       <= swmq_pkg::PROB_C_RST;
      prob_d       <= swmq_pkg::PROB_D_RST;
    end else if (cfg_wen) begin
      case (cfg_addr)
        swmq_pkg::REG_WIDTH:  window_width <= cfg_wdata[5:0];
        swmq_pkg::REG_ALIGN:  alignment    <= cfg_wdata[1:0];
        swmq_pkg::REG_FRAC:   min_fraction <= cfg_wdata;
        swmq_pkg::REG_MODE:   stat_mode    <= cfg_wdata[1:0];
        swmq_pkg::REG_PROB_A: prob_a       <= cfg_wdata;
        swmq_pkg::REG_PROB_B: prob_b       <= cfg_wdata;
        swmq_pkg::REG_PROB_C: prob_c       <= cfg_wdata;
        swmq_pkg::REG_PROB_D: prob_d       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      st              <= S_IDLE;
      present         <= '0;
      stream_position <= '0;
      ring_head       <= '0;
      end_mode        <= 1'b0;
    end else begin
      case (st)
        S_IDLE: begin
          if (accept) begin
            present[ring_head] <= !samples.missing;
            ring_head <= (ring_head == AW'(MAX_WIDTH - 1)) ? '0 : AW'(ring_head + 1'b1);
            w_r      <= w_eff;
            lead_r   <= lead_now;
            end_mode <= samples.stream_end;
            if (samples.stream_end) begin
              k  <= (stream_position < 32'(lead_now)) ? AW'(stream_position) : lead_now;
              st <= S_EMIT;
            end else begin
              k <= lead_now;
              if (stream_position != 32'hFFFF_FFFF) begin
                stream_position <= stream_position + 1'b1;
              end
              if (stream_position >= 32'(lead_now)) begin
                st <= S_EMIT;
              end
            end
          end
        end
        S_EMIT: begin
          hi         <= AW'(w_r - 1'b1 - CW'(lead_r - k));
          d          <= '0;
          c          <= '0;
          sum        <= '0;
          mean_r     <= '0;
          mean_ok_r  <= 1'b0;
          quant_ok_r <= 1'b0;
          for (int n = 0; n < 4; n++) begin
            q_res[n] <= '0;
          end
          st <= S_SRD;
        end
        S_SRD: st <= S_SAC;
        S_SAC: begin
          // Accumulate count and sum over present entries
          if (present[ring_raddr]) begin
            c   <= c + 1'b1;
            sum <= sum + SW'($signed(ring_rdata));
          end
          if (d == hi) begin
            st <= S_QUAL;
          end else begin
            d  <= d + 1'b1;
            st <= S_SRD;
          end
        end
        S_QUAL: begin
          ok <= (c != '0) && (have >= need);
          if ((c != '0) && (have >= need)) begin
            if (do_mean) begin
              st <= S_DIVGO;
            end else begin
              i  <= '0;
              st <= S_RICHK;
            end
          end else begin
            st <= S_OUT;
          end
        end
        S_DIVGO: st <= S_DIVW;
        S_DIVW: begin
          if (div_done) begin
            mean_r    <= sum[SW-1] ? SB'(-div_q) : SB'(div_q);
            mean_ok_r <= 1'b1;
            i         <= '0;
            st        <= do_q ? S_RICHK : S_OUT;
          end
        end
        S_RICHK: begin
          // Skip absent entries in the outer ranking loop
          if (present[slot_of(ring_head, i)]) begin
            st <= S_RIRD;
          end else if (i == hi) begin
            a  <= '0;
            st <= S_QMUL;
          end else begin
            i <= i + 1'b1;
          end
        end
        S_RIRD: st <= S_RILAT;
        S_RILAT: begin
          vi   <= $signed(ring_rdata);
          d    <= '0;
          rank <= '0;
          st   <= S_RJRD;
        end
        S_RJRD: st <= S_RJAC;
        S_RJAC: begin
          if (present[ring_raddr] && vj_less) begin
            rank <= rank + 1'b1;
          end
          if (d == hi) begin
            st <= S_RWR;
          end else begin
            d  <= d + 1'b1;
            st <= S_RJRD;
          end
        end
        S_RWR: begin
          if (i == hi) begin
            a  <= '0;
            st <= S_QMUL;
          end else begin
            i  <= i + 1'b1;
            st <= S_RICHK;
          end
        end
        S_QMUL: begin
          idx <= (17+CW)'(psat * (c - 1'b1));
          st  <= S_QRD0;
        end
        S_QRD0: st <= S_QRD1;
        S_QRD1: begin
          q0 <= $signed(sc_rdata);
          st <= S_QPRD;
        end
        S_QPRD: begin
          // Interpolate toward the next sorted entry
          interp    <= (idx[15:0] != 16'd0) && ((lo + 1'b1) < (CW+1)'(c));
          frac_prod <= frac_full[SB+15:16];
          st        <= S_QADD;
        end
        S_QADD: begin
          q_res[a] <= interp ? SB'(q0 + $signed(frac_prod)) : q0;
          if (a == 2'(NUM_PROBS - 1)) begin
            quant_ok_r <= 1'b1;
            st         <= S_OUT;
          end else begin
            a  <= a + 1'b1;
            st <= S_QMUL;
          end
        end
        S_OUT: begin
          if (results.ready) begin
            if (!end_mode) begin
              st <= S_IDLE;
            end else if (k == '0) begin
              present         <= '0;
              stream_position <= '0;
              ring_head       <= '0;
              st              <= S_IDLE;
            end else begin
              k  <= k - 1'b1;
              st <= S_EMIT;
            end
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  // Result item
  assign results.valid         = (st == S_OUT);
  assign results.mean_value    = mean_r;
  assign results.mean_ok       = mean_ok_r;
  assign results.quant_a       = q_res[0];
  assign results.quant_b       = q_res[1];
  assign results.quant_c       = q_res[2];
  assign results.quant_d       = q_res[3];
  assign results.quant_ok      = quant_ok_r;
  assign results.present_count = 6'(c);
  assign results.final_result  = end_mode && (k == '0);

  // One item in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> !samples.ready)
    else $error("result offered while a new item could be taken");

  // Count never exceeds the window span
  a_count_span: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> ({1'b0, c} <= (CW+1)'(hi) + 1'b1))
    else $error("present count beyond window span");

  // A qualified mean or quantile set implies a qualified window
  a_mean_ok: assert property (@(posedge clk) disable iff (rst)
    results.valid && (results.mean_ok || results.quant_ok) |-> ok && (c != '0))
    else $error("statistic flagged on unqualified window");

  // The final result clears the stream state
  a_final_clear: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.ready && results.final_result |=>
      (ring_head == '0) && (stream_position == '0) && (present == '0))
    else $error("stream state not cleared after final result");

endmodule

`default_nettype wire

// ===== hw/rtl/swmq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module swmq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  wire logic                                 clk,
  input  wire logic                                 we,
  input  wire logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                     wdata,
  input  wire logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] raddr,
  output      logic [WIDTH-1:0]                     rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

`default_nettype wire

// ===== hw/rtl/swmq_div.sv =====
// Serial restoring divider: one quotient bit per cycle.
// No dependencies; used by the top level for the window mean.
`default_nettype none

module swmq_div #(
  parameter int NW = 22,
  parameter int DW = 6
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [NW-1:0] dividend,
  input  wire logic [DW-1:0] divisor,
  output      logic          done,
  output      logic [NW-1:0] quotient
);
  localparam int NCW = $clog2(NW + 1);

  logic [DW-1:0]  rem;
  logic [NW-1:0]  num;
  logic [NCW-1:0] cnt;
  logic           busy;
  logic [DW:0]    rem_sh;
  logic           fits;

  assign rem_sh = {rem, num[NW-1]};
  assign fits   = rem_sh >= {1'b0, divisor};

  // Shift one dividend bit in, subtract when the divisor fits
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= NCW'(NW);
        rem  <= '0;
        num  <= dividend;
      end else if (busy) begin
        rem      <= fits ? DW'(rem_sh - {1'b0, divisor}) : DW'(rem_sh);
        num      <= {num[NW-2:0], 1'b0};
        quotient <= {quotient[NW-2:0], fits};
        cnt      <= cnt - 1'b1;
        if (cnt == NCW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking bench for sliding_window_mean_quantile: directed and random sample series.
// Depends on swmq_pkg, the swmq_in_if/swmq_out_if channels and the block's RTL.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIN_MAX   = swmq_pkg::MAX_WIDTH_DEF;
  localparam int CYCLE_CAP = 3000000;
  localparam int SETTLE    = 2500;

  typedef struct {
    logic signed [15:0] sample;
    bit                 missing;
    bit                 stream_end;
  } sample_item_t;

  typedef struct {
    logic signed [15:0] mean_value;
    bit                 mean_ok;
    logic signed [15:0] quant[4];
    bit                 quant_ok;
    logic [5:0]         present_count;
    bit                 final_result;
  } window_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                        cfg_wen   = 1'b0;
  logic [swmq_pkg::CFG_IW-1:0] cfg_addr  = '0;
  logic [swmq_pkg::CFG_DW-1:0] cfg_wdata = '0;

  swmq_in_if  in_ch();
  swmq_out_if out_ch();

  sliding_window_mean_quantile uut (
    .clk(clk), .rst(rst),
    .cfg_wen(cfg_wen), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .samples(in_ch), .results(out_ch)
  );

  always #6 clk = ~clk;

  // Local copy of the register file
  logic [5:0]  win_width;
  logic [1:0]  align_code;
  logic [16:0] min_frac;
  logic [1:0]  mode_code;
  logic [16:0] prob[4];

  // Local copy of the window state
  logic signed [15:0] ring_val[WIN_MAX];
  bit                 ring_pres[WIN_MAX];
  int unsigned        series_pos;
  int unsigned        ring_ptr;

  sample_item_t   pending_items[$];
  window_result_t expected_results[$];

  int  errors = 0;
  int  items_taken = 0;
  int  results_seen = 0;
  int  finals_seen = 0;
  int  cycles = 0;
  bit  no_idle = 1'b0;
  bit  in_took = 1'b0;
  bit  out_took = 1'b0;
  bit  offering = 1'b0;
  int  tx_gap = 0;
  int  rx_stall = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;

  // Statistics of the window position k steps behind the newest sample
  function automatic window_result_t window_stats(int unsigned k, int unsigned lead,
                                                  int unsigned w, bit fin);
    window_result_t r;
    longint vals[WIN_MAX];
    longint sum, v, q, diff;
    longint unsigned p, idx, fr;
    int unsigned hi, cnt, s, lo;
    int a, b;
    r.mean_value = '0; r.mean_ok = 0; r.quant_ok = 0;
    for (a = 0; a < 4; a++) r.quant[a] = '0;
    hi = w - 1 - (lead - k);
    cnt = 0;
    sum = 0;
    for (int unsigned d = 0; d <= hi && d < WIN_MAX; d++) begin
      s = (ring_ptr + 2 * WIN_MAX - 1 - d) % WIN_MAX;
      if (ring_pres[s]) begin
        vals[cnt] = ring_val[s];
        sum += ring_val[s];
        cnt++;
      end
    end
    if (cnt > 0 && longint'(cnt) * 65536 >= longint'(min_frac) * longint'(w)) begin
      if (mode_code != swmq_pkg::MODE_QUANT) begin
        r.mean_value = 16'(sum / longint'(cnt));
        r.mean_ok = 1;
      end
      if (mode_code != swmq_pkg::MODE_MEAN) begin
        // insertion sort of the present values
        for (a = 1; a < int'(cnt); a++) begin
          v = vals[a];
          b = a;
          while (b > 0 && vals[b-1] > v) begin
            vals[b] = vals[b-1];
            b--;
          end
          vals[b] = v;
        end
        for (a = 0; a < 4; a++) begin
          p = (prob[a] > swmq_pkg::ONE_Q16) ? 65536 : prob[a];
          idx = p * (cnt - 1);
          lo = int'(idx >> 16);
          fr = idx & 64'hFFFF;
          q = vals[lo];
          if (fr != 0 && lo + 1 < cnt) begin
            diff = vals[lo+1] - q;
            q += longint'((fr * longint'(diff)) >> 16);
          end
          r.quant[a] = 16'(q);
        end
        r.quant_ok = 1;
      end
    end
    r.present_count = 6'(cnt);
    r.final_result = fin;
    return r;
  endfunction

  // Advance the window by one accepted item and queue the results it causes
  task automatic predict_item(sample_item_t it);
    int unsigned w, lead, t, slot, k;
    w = (win_width == 0) ? 1 : (win_width > WIN_MAX) ? WIN_MAX : win_width;
    if (align_code == swmq_pkg::ALIGN_LEFT) lead = w - 1;
    else if (align_code == swmq_pkg::ALIGN_CENTRE) lead = w - 1 - (w - 1) / 2;
    else lead = 0;
    t = series_pos;
    slot = ring_ptr % WIN_MAX;
    ring_val[slot] = it.sample;
    ring_pres[slot] = !it.missing;
    ring_ptr = (slot + 1) % WIN_MAX;
    if (!it.stream_end) begin
      if (t >= lead)
        expected_results.insert(expected_results.size(), window_stats(lead, lead, w, 1'b0));
      if (series_pos != 32'hFFFF_FFFF) series_pos++;
    end else begin
      k = (t < lead) ? t : lead;
      forever begin
        expected_results.insert(expected_results.size(), window_stats(k, lead, w, k == 0));
        if (k == 0) break;
        k--;
      end
      for (int i = 0; i < WIN_MAX; i++) ring_pres[i] = 0;
      series_pos = 0;
      ring_ptr = 0;
    end
  endtask

  function automatic void check_field(string name, longint e, longint a);
    if (e != a) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, e, a);
    end
  endfunction

  // Sample handshakes, check results, count cycles
  always @(posedge clk) begin
    window_result_t e;
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Simulation FAILED");
      $finish;
    end
    if (!rst && in_ch.valid && in_ch.ready) begin
      predict_item('{in_ch.sample, in_ch.missing, in_ch.stream_end});
      items_taken++;
      in_took = 1;
    end
    if (!rst && out_ch.valid && out_ch.ready) begin
      out_took = 1;
      results_seen++;
      if (out_ch.final_result) finals_seen++;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, nothing expected (count %0d)",
                 $time, out_ch.present_count);
      end else begin
        e = expected_results.pop_front();
        check_field("mean_value", e.mean_value, out_ch.mean_value);
        check_field("mean_ok", e.mean_ok, out_ch.mean_ok);
        check_field("quant_a", e.quant[0], out_ch.quant_a);
        check_field("quant_b", e.quant[1], out_ch.quant_b);
        check_field("quant_c", e.quant[2], out_ch.quant_c);
        check_field("quant_d", e.quant[3], out_ch.quant_d);
        check_field("quant_ok", e.quant_ok, out_ch.quant_ok);
        check_field("present_count", e.present_count, out_ch.present_count);
        check_field("final_result", e.final_result, out_ch.final_result);
      end
    end
  end

  // Sample driver: present the next item after a random gap
  always @(negedge clk) begin
    sample_item_t cur;
    bit nv;
    nv = in_ch.valid;
    cur = '{in_ch.sample, in_ch.missing, in_ch.stream_end};
    if (in_took) begin
      in_took = 0;
      offering = 0;
      tx_gap = no_idle ? 0 : $urandom_range(0, 10);
    end
    if (rst) begin
      nv = 0;
    end else if (!offering) begin
      if (tx_gap > 0) begin
        tx_gap--;
        nv = 0;
      end else if (pending_items.size() > 0) begin
        cur = pending_items.pop_front();
        offering = 1;
        nv = 1;
      end else begin
        nv = 0;
      end
    end
    in_ch.valid <= nv;
    in_ch.sample <= cur.sample;
    in_ch.missing <= cur.missing;
    in_ch.stream_end <= cur.stream_end;
  end

  // Result receiver: random stalls plus one long hold
  always @(negedge clk) begin
    bit nr;
    if (out_took) begin
      out_took = 0;
      rx_stall = no_idle ? 0 : $urandom_range(0, 10);
    end
    // hold off the receiver once for a long stretch
    if (!hold_done && results_seen >= 30) begin
      hold_done = 1;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      nr = 0;
    end else if (rx_stall > 0) begin
      rx_stall--;
      nr = 0;
    end else begin
      nr = 1;
    end
    out_ch.ready <= nr && !rst;
  end

  task automatic write_reg(logic [swmq_pkg::CFG_IW-1:0] idx, int val);
    @(negedge clk);
    cfg_wen <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val[swmq_pkg::CFG_DW-1:0];
    case (idx)
      swmq_pkg::REG_WIDTH:  win_width = val[5:0];
      swmq_pkg::REG_ALIGN:  align_code = val[1:0];
      swmq_pkg::REG_FRAC:   min_frac = val[16:0];
      swmq_pkg::REG_MODE:   mode_code = val[1:0];
      swmq_pkg::REG_PROB_A: prob[0] = val[16:0];
      swmq_pkg::REG_PROB_B: prob[1] = val[16:0];
      swmq_pkg::REG_PROB_C: prob[2] = val[16:0];
      default:              prob[3] = val[16:0];
    endcase
    @(negedge clk);
    cfg_wen <= 1'b0;
  endtask

  task automatic setup(int w, int al, int fr, int md, int pa, int pb, int pc, int pd);
    write_reg(swmq_pkg::REG_WIDTH, w);
    write_reg(swmq_pkg::REG_ALIGN, al);
    write_reg(swmq_pkg::REG_FRAC, fr);
    write_reg(swmq_pkg::REG_MODE, md);
    write_reg(swmq_pkg::REG_PROB_A, pa);
    write_reg(swmq_pkg::REG_PROB_B, pb);
    write_reg(swmq_pkg::REG_PROB_C, pc);
    write_reg(swmq_pkg::REG_PROB_D, pd);
  endtask

  task automatic add_item(int s, bit m, bit e);
    sample_item_t it;
    it.sample = 16'(s);
    it.missing = m;
    it.stream_end = e;
    pending_items.insert(pending_items.size(), it);
  endtask

  // Wait for every item and result, then let the block settle
  task automatic drain();
    while (pending_items.size() > 0 || offering || expected_results.size() > 0)
      @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // One random series: mostly clean, sometimes narrow values for ties
  task automatic add_series(int len, bit close);
    bit narrow;
    int miss_pct;
    narrow = ($urandom_range(0, 3) == 0);
    miss_pct = $urandom_range(0, 3) == 0 ? 70 : 15;
    for (int i = 0; i < len; i++)
      add_item(narrow ? $urandom_range(0, 6) - 3 : $urandom_range(0, 65535),
               $urandom_range(0, 99) < miss_pct, close && i == len - 1);
  endtask

  function automatic int rand_prob();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 65536;
      2: return $urandom_range(65537, 131071);
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  initial begin
    int w, n, len;
    in_ch.valid = 1'b0;
    in_ch.sample = '0;
    in_ch.missing = 1'b0;
    in_ch.stream_end = 1'b0;
    out_ch.ready = 1'b0;
    win_width = swmq_pkg::WIDTH_RST; align_code = swmq_pkg::ALIGN_RST;
    min_frac = swmq_pkg::FRAC_RST;
    mode_code = swmq_pkg::MODE_RST;
    prob[0] = swmq_pkg::PROB_A_RST; prob[1] = swmq_pkg::PROB_B_RST;
    prob[2] = swmq_pkg::PROB_C_RST; prob[3] = swmq_pkg::PROB_D_RST;
    for (int i = 0; i < WIN_MAX; i++) begin
      ring_val[i] = '0;
      ring_pres[i] = 0;
    end
    series_pos = 0;
    ring_ptr = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset defaults: short right-aligned series
    add_item(100, 0, 0); add_item(-100, 0, 0); add_item(7, 1, 1);
    drain();

    // Extremes, missing values, saturating probability, quantile ends
    setup(4, int'(swmq_pkg::ALIGN_RIGHT), 0, int'(swmq_pkg::MODE_BOTH),
          0, 65536, 32768, 100000);
    add_item(32767, 0, 0); add_item(-32768, 0, 0); add_item(32767, 0, 0);
    add_item(0, 1, 0); add_item(-32768, 0, 0); add_item(-1, 1, 0); add_item(5, 1, 1);
    drain();

    // Left aligned, full fraction, quantiles only, series shorter than the lag
    setup(3, int'(swmq_pkg::ALIGN_LEFT), 65536, int'(swmq_pkg::MODE_QUANT),
          1, 65535, 21845, 43690);
    add_item(-32768, 0, 1);
    add_item(10, 0, 0); add_item(20, 1, 0); add_item(30, 0, 0); add_item(40, 0, 1);
    drain();

    // Codes 3 for alignment and mode, then centre with a fraction never met
    setup(5, 3, 0, 3, 32768, 16384, 49152, 131071);
    add_item(1, 0, 0); add_item(2, 0, 0); add_item(3, 0, 1);
    drain();
    setup(5, int'(swmq_pkg::ALIGN_CENTRE), 131071, int'(swmq_pkg::MODE_BOTH),
          32768, 16384, 49152, 62259);
    add_item(1, 0, 0); add_item(2, 0, 0); add_item(3, 0, 0); add_item(4, 0, 1);
    drain();

    // Width 0 acts as 1, width above the maximum acts as the maximum
    setup(0, int'(swmq_pkg::ALIGN_RIGHT), 65536, int'(swmq_pkg::MODE_MEAN), 0, 0, 0, 0);
    add_item(-5, 0, 0); add_item(9, 1, 0); add_item(3, 0, 1);
    drain();
    write_reg(swmq_pkg::REG_WIDTH, 63);
    write_reg(swmq_pkg::REG_ALIGN, int'(swmq_pkg::ALIGN_CENTRE));
    write_reg(swmq_pkg::REG_FRAC, 0);
    add_item(-3, 0, 0); add_item(4, 0, 0); add_item(-7, 0, 1);
    drain();

    // Random phases, small windows mostly; one phase at the full width
    for (int ph = 0; ph < 11; ph++) begin
      no_idle = ($urandom_range(0, 3) == 0);
      w = (ph == 5) ? 32 : $urandom_range(1, 8);
      setup(w, $urandom_range(0, 3),
            $urandom_range(0, 3) == 0 ? $urandom_range(0, 131071) : $urandom_range(0, 65536),
            $urandom_range(0, 3), rand_prob(), rand_prob(), rand_prob(), rand_prob());
      n = 0;
      while (n < ((ph == 5) ? 16 : 34)) begin
        len = (ph == 5) ? 8 : $urandom_range(1, 14);
        // most series close properly; some stay open into the next setting
        add_series(len, $urandom_range(0, 4) != 0);
        n += len;
      end
      drain();
    end

    no_idle = 0;
    $display("Covered %0d sample items and %0d results (%0d series ends).",
             items_taken, results_seen, finals_seen);
    $display("Widths 0..63, all alignments, modes and fraction extremes exercised.");
    if (errors == 0 && expected_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d results never arrived", errors, expected_results.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
hw/rtl/swmq_pkg.sv
hw/rtl/swmq_if.sv
hw/rtl/swmq_ram.sv
hw/rtl/swmq_div.sv
hw/rtl/sliding_window_mean_quantile.sv
verif/tb_top.sv
